>>> src/assert_macros.svh
// assertion macros used by the allocator datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, masked while reset is asserted
`define BBFPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bbfpa assertion failed");
// checked property, also evaluated during reset
`define BBFPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bbfpa assertion failed");
`else
`define BBFPA_ASSERT(lbl, clk, rst_n, prop)
`define BBFPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/bbfpa_pkg.sv
// shared constants and types for the best-fit page allocator
`default_nettype none

package bbfpa_pkg;

  localparam int unsigned POOL_PAGES = 1024;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_IDX_W = $clog2(POOL_PAGES);
  localparam int unsigned ROW_BITS   = 32;
  localparam int unsigned BIT_IDX_W  = $clog2(ROW_BITS);
  localparam int unsigned ROWS       = POOL_PAGES / ROW_BITS;
  localparam int unsigned ROW_IDX_W  = PAGE_IDX_W - BIT_IDX_W;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned WIDE_W     = ADDR_W + 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] phys_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_address;
    logic              accepted;
    logic [CNT_W-1:0]  already_free_pages;
    logic [CNT_W-1:0]  free_pages;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic chk;
    logic scan_init;
    logic rd;
    logic scan_ld;
    logic scan_bit;
    logic alloc_init;
    logic free_init;
    logic mod_wr;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic alloc_ok;
    logic free_ok;
    logic cnt_zero;
    logic found;
    logic last_bit;
    logic last_row;
    logic mod_last;
  } sts_t;

endpackage

`default_nettype wire

>>> src/bbfpa_ctrl.sv
// sequencer for the allocator: check, bitmap scan, row update, result
`default_nettype none

module bbfpa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  output bbfpa_pkg::cmd_t      cmd_o,
  input  wire bbfpa_pkg::sts_t sts_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_DECIDE    = 4'd2;
  localparam logic [3:0] S_SCAN_RD   = 4'd3;
  localparam logic [3:0] S_SCAN_LD   = 4'd4;
  localparam logic [3:0] S_SCAN_BIT  = 4'd5;
  localparam logic [3:0] S_ALLOC_DEC = 4'd6;
  localparam logic [3:0] S_MOD_RD    = 4'd7;
  localparam logic [3:0] S_MOD_WR    = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.is_free) begin
          if (sts_i.alloc_ok) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (sts_i.free_ok && !sts_i.cnt_zero) begin
          cmd_o.free_init = 1'b1;
          state_d         = S_MOD_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SCAN_LD;
      end
      S_SCAN_LD: begin
        cmd_o.scan_ld = 1'b1;
        state_d       = S_SCAN_BIT;
      end
      S_SCAN_BIT: begin
        cmd_o.scan_bit = 1'b1;
        if (sts_i.last_bit) begin
          state_d = sts_i.last_row ? S_ALLOC_DEC : S_SCAN_RD;
        end
      end
      S_ALLOC_DEC: begin
        if (sts_i.found) begin
          cmd_o.alloc_init = 1'b1;
          state_d          = S_MOD_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOD_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MOD_WR;
      end
      S_MOD_WR: begin
        cmd_o.mod_wr = 1'b1;
        state_d      = sts_i.mod_last ? S_DONE : S_MOD_RD;
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> src/bbfpa_dp.sv
// allocator datapath: page bitmap memory, best-fit scan, range update, counters
`default_nettype none
`include "assert_macros.svh"

module bbfpa_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bbfpa_pkg::ADDR_W-1:0]     cfg_wdata_i,
  input  wire bbfpa_pkg::req_t                  req_i,
  input  wire bbfpa_pkg::cmd_t                  cmd_i,
  output bbfpa_pkg::sts_t                       sts_o,
  output logic                                  done_o,
  output bbfpa_pkg::rsp_t                       rsp_o
);

  localparam int unsigned CNT_W      = bbfpa_pkg::CNT_W;
  localparam int unsigned ADDR_W     = bbfpa_pkg::ADDR_W;
  localparam int unsigned WIDE_W     = bbfpa_pkg::WIDE_W;
  localparam int unsigned ROW_BITS   = bbfpa_pkg::ROW_BITS;
  localparam int unsigned ROWS       = bbfpa_pkg::ROWS;
  localparam int unsigned ROW_IDX_W  = bbfpa_pkg::ROW_IDX_W;
  localparam int unsigned BIT_IDX_W  = bbfpa_pkg::BIT_IDX_W;
  localparam int unsigned PAGE_IDX_W = bbfpa_pkg::PAGE_IDX_W;
  localparam int unsigned PAGE_SHIFT = bbfpa_pkg::PAGE_SHIFT;
  localparam int unsigned HIT_W      = BIT_IDX_W + 1;
  localparam int unsigned ADDR_PAD   = ADDR_W - PAGE_IDX_W - PAGE_SHIFT;
  localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(bbfpa_pkg::POOL_PAGES);
  localparam logic [WIDE_W-1:0] POOL_SPAN = WIDE_W'(bbfpa_pkg::POOL_PAGES) << PAGE_SHIFT;

  // page bitmap, one row of pages per word, 1 = page in use
  logic [ROW_BITS-1:0] map_mem [ROWS];
  logic [ROW_BITS-1:0] rdata_q;
  logic [ROWS-1:0]     valid_q;

  logic [ADDR_W-1:0]     pool_base_q;
  logic [CNT_W-1:0]      free_count_q;
  bbfpa_pkg::req_t       req_q;
  logic                  alloc_ok_q, free_ok_q, found_q, done_q;
  logic [ROW_IDX_W-1:0]  row_q;
  logic [BIT_IDX_W-1:0]  bit_q;
  logic [ROW_BITS-1:0]   sh_q;
  logic [CNT_W-1:0]      run_q, fit_len_q, cleared_q;
  logic [PAGE_IDX_W-1:0] best_start_q, lo_q, hi_q;
  bbfpa_pkg::rsp_t       rsp_q;

  logic                  is_free, base_on;
  logic [WIDE_W-1:0]     end_w, limit_w;
  logic [ADDR_W-1:0]     offset;
  logic                  alloc_ok_d, free_ok_d;
  logic                  scan_b, scan_last, scan_eval, scan_take;
  logic [CNT_W-1:0]      run_inc, ev_run, ev_end;
  logic [PAGE_IDX_W-1:0] lo_sel, hi_sel;
  logic [ROW_BITS-1:0]   row_eff, row_mask, row_new, hit;
  logic [HIT_W-1:0]      hit_cnt;
  logic [CNT_W-1:0]      fc_new;

  assign is_free = (req_q.func == bbfpa_pkg::FUNC_FREE);
  assign base_on = (pool_base_q != '0);

  // range checks, done in wide arithmetic so nothing wraps
  assign end_w   = {{(WIDE_W-ADDR_W){1'b0}}, req_q.phys_address} +
                   ({{(WIDE_W-CNT_W){1'b0}}, req_q.page_count} << PAGE_SHIFT);
  assign limit_w = {{(WIDE_W-ADDR_W){1'b0}}, pool_base_q} + POOL_SPAN;
  assign offset  = req_q.phys_address - pool_base_q;
  assign free_ok_d  = base_on && (req_q.phys_address >= pool_base_q) && (end_w <= limit_w);
  assign alloc_ok_d = base_on && (req_q.page_count != '0) && (req_q.page_count <= POOL_CNT);

  // best-fit scan, one page per cycle, pausing at each row fetch; a used page or the map end closes a run
  assign scan_b    = sh_q[0];
  assign scan_last = (row_q == ROW_IDX_W'(ROWS - 1)) && (bit_q == BIT_IDX_W'(ROW_BITS - 1));
  assign run_inc   = run_q + CNT_W'(1);
  assign ev_run    = scan_b ? run_q : run_inc;
  assign ev_end    = scan_b ? {{(CNT_W-PAGE_IDX_W){1'b0}}, row_q, bit_q} : POOL_CNT;
  assign scan_eval = scan_b || scan_last;
  assign scan_take = scan_eval && (ev_run >= req_q.page_count) && (ev_run < fit_len_q);

  // page range of the update
  assign lo_sel = cmd_i.alloc_init ? best_start_q : lo_q;
  assign hi_sel = PAGE_IDX_W'({1'b0, lo_sel} + req_q.page_count - CNT_W'(1));

  assign row_eff = valid_q[row_q] ? rdata_q : '0;

  always_comb begin
    logic [PAGE_IDX_W-1:0] pos;
    pos = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      pos         = {row_q, BIT_IDX_W'(j)};
      row_mask[j] = (pos >= lo_q) && (pos <= hi_q);
    end
  end

  assign row_new = is_free ? (row_eff & ~row_mask) : (row_eff | row_mask);
  assign hit     = row_eff & row_mask;

  // used pages inside the freed part of this row, nibble by nibble
  always_comb begin
    hit_cnt = '0;
    for (int n = 0; n < ROW_BITS / 4; n++) begin
      hit_cnt = hit_cnt + HIT_W'(hit[4*n]) + HIT_W'(hit[4*n+1]) +
                HIT_W'(hit[4*n+2]) + HIT_W'(hit[4*n+3]);
    end
  end

  always_comb begin
    fc_new = free_count_q;
    if (is_free) begin
      if (free_ok_q) begin
        fc_new = free_count_q + cleared_q;
      end
    end else if (found_q) begin
      fc_new = free_count_q - req_q.page_count;
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_wr) begin
      map_mem[row_q] <= row_new;
    end
    if (cmd_i.rd) begin
      rdata_q <= map_mem[row_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      free_count_q <= POOL_CNT;
      valid_q      <= '0;
      alloc_ok_q   <= 1'b0;
      free_ok_q    <= 1'b0;
      found_q      <= 1'b0;
      done_q       <= 1'b0;
      row_q        <= '0;
      bit_q        <= '0;
    end else begin
      done_q <= cmd_i.done;
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
      if (cmd_i.cap) begin
        found_q    <= 1'b0;
        alloc_ok_q <= 1'b0;
        free_ok_q  <= 1'b0;
      end
      if (cmd_i.chk) begin
        alloc_ok_q <= alloc_ok_d;
        free_ok_q  <= free_ok_d;
      end
      if (cmd_i.scan_init) begin
        row_q <= '0;
        bit_q <= '0;
      end
      if (cmd_i.scan_bit) begin
        bit_q <= bit_q + BIT_IDX_W'(1);
        if (bit_q == BIT_IDX_W'(ROW_BITS - 1)) begin
          row_q <= row_q + ROW_IDX_W'(1);
        end
        if (scan_take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.alloc_init || cmd_i.free_init) begin
        row_q <= lo_sel[PAGE_IDX_W-1 -: ROW_IDX_W];
      end
      if (cmd_i.mod_wr) begin
        valid_q[row_q] <= 1'b1;
        row_q          <= row_q + ROW_IDX_W'(1);
      end
      if (cmd_i.done) begin
        free_count_q <= fc_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q     <= req_i;
      cleared_q <= '0;
    end
    if (cmd_i.chk) begin
      lo_q <= offset[PAGE_SHIFT +: PAGE_IDX_W];
    end
    if (cmd_i.scan_init) begin
      run_q     <= '0;
      fit_len_q <= POOL_CNT + CNT_W'(1);
    end
    if (cmd_i.scan_ld) begin
      sh_q <= row_eff;
    end
    if (cmd_i.scan_bit) begin
      sh_q  <= sh_q >> 1;
      run_q <= scan_b ? '0 : run_inc;
      if (scan_take) begin
        fit_len_q    <= ev_run;
        best_start_q <= PAGE_IDX_W'(ev_end - ev_run);
      end
    end
    if (cmd_i.alloc_init || cmd_i.free_init) begin
      lo_q      <= lo_sel;
      hi_q      <= hi_sel;
      cleared_q <= '0;
    end
    if (cmd_i.mod_wr) begin
      cleared_q <= cleared_q + CNT_W'(hit_cnt);
    end
    if (cmd_i.done) begin
      rsp_q.alloc_address <= (!is_free && found_q) ?
        pool_base_q + {{ADDR_PAD{1'b0}}, best_start_q, {PAGE_SHIFT{1'b0}}} : '0;
      rsp_q.accepted <= is_free ? free_ok_q : found_q;
      rsp_q.already_free_pages <= (is_free && free_ok_q) ?
        req_q.page_count - cleared_q : '0;
      rsp_q.free_pages <= base_on ? fc_new : '0;
    end
  end

  assign sts_o.is_free  = is_free;
  assign sts_o.alloc_ok = alloc_ok_q;
  assign sts_o.free_ok  = free_ok_q;
  assign sts_o.cnt_zero = (req_q.page_count == '0);
  assign sts_o.found    = found_q;
  assign sts_o.last_bit = (bit_q == BIT_IDX_W'(ROW_BITS - 1));
  assign sts_o.last_row = (row_q == ROW_IDX_W'(ROWS - 1));
  assign sts_o.mod_last = (row_q == hi_q[PAGE_IDX_W-1 -: ROW_IDX_W]);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `BBFPA_ASSERT_ALWAYS(a_reset_map_free, clk_i, !rst_ni |=> (valid_q == '0 && free_count_q == POOL_CNT))
  `BBFPA_ASSERT(a_alloc_no_underflow, clk_i, rst_ni, (cmd_i.done && !is_free && found_q) |-> (free_count_q >= req_q.page_count))
  `BBFPA_ASSERT(a_free_cleared_bound, clk_i, rst_ni, (cmd_i.done && is_free && free_ok_q) |-> (cleared_q <= req_q.page_count))
  `BBFPA_ASSERT(a_fit_len_fits, clk_i, rst_ni, (cmd_i.scan_bit && found_q) |-> (fit_len_q >= req_q.page_count))
  `BBFPA_ASSERT(a_mod_in_range, clk_i, rst_ni, cmd_i.mod_wr |-> (row_q <= hi_q[PAGE_IDX_W-1 -: ROW_IDX_W]))

endmodule

`default_nettype wire

>>> src/bitmap_best_fit_page_allocator_core.sv
// top level of the best-fit page allocator: sequencer plus datapath
//
//   port group         dir  timing
//   start/busy/req_i   in   transaction taken when start is high and busy is low
//   done_o/rsp_o       out  one-cycle strobe, result valid in that cycle only
//   cfg_we_i/wdata     in   pool base written on any edge with cfg_we_i high
//
// allocate: bit-serial scan of the whole map, one page per cycle, pausing at each row
//   fetch; then one read and one write of the map memory per 32-page row in the run
// free: one read and one write of the map memory per row in the range
// rejected requests skip the scan and the update; done_o is registered from the last step
// reset marks every map row not yet written as free, so no clearing pass is needed
// results cannot be stalled; busy stays high until done_o is issued
`default_nettype none

module bitmap_best_fit_page_allocator_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bbfpa_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  wire logic                         start,
  output logic                              busy,
  input  wire bbfpa_pkg::req_t              req_i,
  output logic                              done_o,
  output bbfpa_pkg::rsp_t                   rsp_o
);

  bbfpa_pkg::cmd_t cmd;
  bbfpa_pkg::sts_t sts;

  bbfpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  bbfpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
